/* hw/rtl/revc_pkg.sv */
package revc_pkg;

    // Number of reported walk states: -9..-1 and 1..9.
    localparam int NUM_STATES = 18;
    localparam int STATE_SPAN = 9;
    localparam int SLOT_W = 5;
    localparam int STATE_W = 5;
    localparam int MIN_CYCLES_RESET = 500;

    // Port request toward the visit-count memory; data travels beside it.
    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
    } t_ram_ctl;

    // Maps a memory slot (0..17) to its walk state, two's complement.
    function automatic logic [STATE_W-1:0] state_of_slot(input logic [SLOT_W-1:0] slot);
        logic [STATE_W-1:0] s;
        if (slot < SLOT_W'(STATE_SPAN)) begin
            s = STATE_W'(slot) - STATE_W'(STATE_SPAN);
        end else begin
            s = STATE_W'(slot) - STATE_W'(STATE_SPAN - 1);
        end
        return s;
    endfunction

endpackage

/* hw/rtl/random_excursion_variant_counter.sv */
// Random excursions variant counter: the counting stage of the random excursions
// variant test. Each input word carries one sequence bit; a 1 steps a walk sum up and
// a 0 steps it down. Returns to zero are counted as cycles, and visits to each walk
// state from -9 to 9 (zero excluded) are counted in an 18-entry memory. A word with
// last_bit set closes the open cycle if the sum is nonzero, and then 18 result words
// follow in state order -9..-1, 1..9, each with the visit count, the cycle total and an
// applicable flag (cycle total at least min_cycles); the eighteenth carries last_result.
// All run state is then cleared, while min_cycles keeps its value. The walk sum and all
// counters saturate at MAX_LEN. After reset the memory is zeroed one entry per cycle, and
// the input stalls until that is done. Input words are then taken one per clock while a
// run goes on: a word's visit counter is read from the memory at acceptance and written
// back incremented in the cycle after. After a last word the input stalls until the
// readout finishes: any pending write back lands, then each entry is read from the memory
// and loaded into the output register in state order. A last word that leaves the sum at
// zero or outside -9..9 has no write back. Output stalls that hold a loaded result word
// before the eighteenth has been loaded lengthen the readout. Results are taken from an
// output register, and the next run may start while the final result word still waits
// there. The erfc p-value computation is left to software.
module random_excursion_variant_counter #(
    parameter int MAX_LEN = 16777216
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_we,
    input  logic [$clog2(MAX_LEN+1)-1:0]                 i_cfg_wdata,
    input  logic                                         i_valid,
    output logic                                         o_stall,
    input  logic                                         i_bit_req,
    input  logic                                         i_last_bit,
    output logic                                         o_valid,
    input  logic                                         i_stall,
    output logic signed [revc_pkg::STATE_W-1:0]          o_state_value,
    output logic [$clog2(MAX_LEN+1)-1:0]                 o_visit_count,
    output logic [$clog2(MAX_LEN+1)-1:0]                 o_cycle_total,
    output logic                                         o_applicable,
    output logic                                         o_last_result
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [CNT_W-1:0]   r_min_cycles;
    revc_pkg::t_ram_ctl walk_ctl, dump_ctl;
    logic [CNT_W-1:0]   walk_wdata, dump_wdata;
    logic [CNT_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]   ram_wdata;
    logic [CNT_W-1:0]   cycles;
    logic               run;
    logic               clearing;
    logic               dump_done;
    logic               ram_re, ram_we;
    logic [revc_pkg::SLOT_W-1:0] ram_raddr, ram_waddr;

    // The user must write the threshold register only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cycles <= CNT_W'(revc_pkg::MIN_CYCLES_RESET);
        end else if (i_cfg_we) begin
            r_min_cycles <= i_cfg_wdata;
        end
    end

    revc_walk #(
        .CNT_W   (CNT_W),
        .MAX_LEN (MAX_LEN)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_bit_req   (i_bit_req),
        .i_last_bit  (i_last_bit),
        .o_stall     (o_stall),
        .i_ram_rdata (ram_rdata),
        .o_ram_ctl   (walk_ctl),
        .o_ram_wdata (walk_wdata),
        .i_clear     (clearing),
        .i_dump_done (dump_done),
        .o_run       (run),
        .o_cycles    (cycles)
    );

    revc_dump #(
        .CNT_W (CNT_W)
    ) u_dump (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run         (run),
        .i_cycles      (cycles),
        .i_min_cycles  (r_min_cycles),
        .i_ram_rdata   (ram_rdata),
        .o_ram_ctl     (dump_ctl),
        .o_ram_wdata   (dump_wdata),
        .o_clear       (clearing),
        .o_done        (dump_done),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_state_value (o_state_value),
        .o_visit_count (o_visit_count),
        .o_cycle_total (o_cycle_total),
        .o_applicable  (o_applicable),
        .o_last_result (o_last_result)
    );

    // The walk stage and the readout never use the memory in the same cycle:
    // input words are stalled for the clearing pass after reset and for the whole
    // readout, which starts only once the last word's write back has landed.
    assign ram_re    = walk_ctl.re || dump_ctl.re;
    assign ram_raddr = walk_ctl.re ? walk_ctl.raddr : dump_ctl.raddr;
    assign ram_we    = walk_ctl.we || dump_ctl.we;
    assign ram_waddr = walk_ctl.we ? walk_ctl.waddr : dump_ctl.waddr;
    assign ram_wdata = walk_ctl.we ? walk_wdata : dump_wdata;

    revc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (revc_pkg::NUM_STATES)
    ) u_visit_ram (
        .i_clk   (i_clk),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

/* hw/rtl/revc_ram.sv */
module revc_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 18
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and a write to the same entry on one edge return the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/revc_walk.sv */
module revc_walk #(
    parameter int CNT_W   = 25,
    parameter int MAX_LEN = 16777216
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_bit_req,
    input  logic                  i_last_bit,
    output logic                  o_stall,
    input  logic [CNT_W-1:0]      i_ram_rdata,
    output revc_pkg::t_ram_ctl    o_ram_ctl,
    output logic [CNT_W-1:0]      o_ram_wdata,
    input  logic                  i_clear,
    input  logic                  i_dump_done,
    output logic                  o_run,
    output logic [CNT_W-1:0]      o_cycles
);

    localparam int SUM_W = CNT_W + 1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(MAX_LEN);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;
    localparam logic signed [SUM_W-1:0] SPAN_HI = SUM_W'(revc_pkg::STATE_SPAN);
    localparam logic signed [SUM_W-1:0] SPAN_LO = -SPAN_HI;
    localparam logic [CNT_W-1:0]        CNT_MAX = CNT_W'(MAX_LEN);

    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]              r_cycles;
    logic                          r_dump;
    logic                          r_s1_valid;
    logic [revc_pkg::SLOT_W-1:0]   r_s1_slot;
    logic                          accept;
    logic                          in_range;
    logic                          cyc_inc;
    logic [revc_pkg::SLOT_W-1:0]   slot_lo, slot;

    // No word is taken while the memory is being cleared after reset.
    assign accept = i_valid && !r_dump && !i_clear;

    always_comb begin
        n_sum = r_sum;
        if (i_bit_req) begin
            if (r_sum != SUM_MAX) begin
                n_sum = r_sum + SUM_W'(1);
            end
        end else begin
            if (r_sum != SUM_MIN) begin
                n_sum = r_sum - SUM_W'(1);
            end
        end
    end

    assign in_range = (n_sum >= SPAN_LO) && (n_sum <= SPAN_HI) && (n_sum != '0);
    assign slot_lo  = n_sum[revc_pkg::SLOT_W-1:0];
    assign slot     = n_sum[SUM_W-1] ? slot_lo + revc_pkg::SLOT_W'(revc_pkg::STATE_SPAN)
                                     : slot_lo + revc_pkg::SLOT_W'(revc_pkg::STATE_SPAN - 1);

    // A return to zero closes a cycle; the last word closes the open cycle if any.
    // When the two coincide they close the same cycle, so one saturating increment covers both.
    assign cyc_inc = (n_sum == '0) || i_last_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_cycles   <= '0;
            r_dump     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && in_range;
            if (accept) begin
                r_sum <= i_last_bit ? '0 : n_sum;
                if (cyc_inc && (r_cycles < CNT_MAX)) begin
                    r_cycles <= r_cycles + CNT_W'(1);
                end
                if (i_last_bit) begin
                    r_dump <= 1'b1;
                end
            end
            if (i_dump_done) begin
                r_dump   <= 1'b0;
                r_cycles <= '0;
            end
        end
        if (accept) begin
            r_s1_slot <= slot;
        end
    end

    // Read at acceptance, saturating increment and write back in the following cycle.
    // Consecutive words always hit different slots, so the write never races a read.
    always_comb begin
        o_ram_ctl.re    = accept && in_range;
        o_ram_ctl.raddr = slot;
        o_ram_ctl.we    = r_s1_valid;
        o_ram_ctl.waddr = r_s1_slot;
    end

    assign o_ram_wdata = (i_ram_rdata < CNT_MAX) ? i_ram_rdata + CNT_W'(1) : i_ram_rdata;
    assign o_stall     = r_dump || i_clear;
    assign o_run       = r_dump && !r_s1_valid;
    assign o_cycles    = r_cycles;

endmodule

/* hw/rtl/revc_dump.sv */
module revc_dump #(
    parameter int CNT_W = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_run,
    input  logic [CNT_W-1:0]                    i_cycles,
    input  logic [CNT_W-1:0]                    i_min_cycles,
    input  logic [CNT_W-1:0]                    i_ram_rdata,
    output revc_pkg::t_ram_ctl                  o_ram_ctl,
    output logic [CNT_W-1:0]                    o_ram_wdata,
    output logic                                o_clear,
    output logic                                o_done,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [revc_pkg::STATE_W-1:0] o_state_value,
    output logic [CNT_W-1:0]                    o_visit_count,
    output logic [CNT_W-1:0]                    o_cycle_total,
    output logic                                o_applicable,
    output logic                                o_last_result
);

    localparam logic [revc_pkg::SLOT_W-1:0] SLOT_END  = revc_pkg::SLOT_W'(revc_pkg::NUM_STATES);
    localparam logic [revc_pkg::SLOT_W-1:0] SLOT_LAST =
        revc_pkg::SLOT_W'(revc_pkg::NUM_STATES - 1);

    logic [revc_pkg::SLOT_W-1:0]  r_idx;
    logic [revc_pkg::SLOT_W-1:0]  r_pend_idx;
    logic                         r_pend;
    logic                         r_clear;
    logic                         r_out_valid;
    logic [revc_pkg::STATE_W-1:0] r_state;
    logic [CNT_W-1:0]             r_visits;
    logic [CNT_W-1:0]             r_total;
    logic                         r_appl;
    logic                         r_last;
    logic                         load;
    logic                         issue;

    // The memory output holds while no read is issued, so it serves as a skid stage.
    assign load  = r_pend && (!r_out_valid || !i_stall);
    assign issue = i_run && (r_idx != SLOT_END) && (!r_pend || load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_clear     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_idx  <= r_idx + revc_pkg::SLOT_W'(1);
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
            if (o_done) begin
                r_idx <= '0;
            end
            // After reset every entry is zeroed once, one per cycle.
            if (r_clear) begin
                if (r_idx == SLOT_LAST) begin
                    r_clear <= 1'b0;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + revc_pkg::SLOT_W'(1);
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (issue) begin
            r_pend_idx <= r_idx;
        end
        if (load) begin
            r_state  <= revc_pkg::state_of_slot(r_pend_idx);
            r_visits <= i_ram_rdata;
            r_total  <= i_cycles;
            r_appl   <= (i_cycles >= i_min_cycles);
            r_last   <= (r_pend_idx == SLOT_LAST);
        end
    end

    // Each entry is cleared by the same edge that reads it out.
    always_comb begin
        o_ram_ctl.re    = issue;
        o_ram_ctl.raddr = r_idx;
        o_ram_ctl.we    = issue || r_clear;
        o_ram_ctl.waddr = r_idx;
    end

    assign o_ram_wdata   = '0;
    assign o_clear       = r_clear;
    assign o_done        = load && (r_pend_idx == SLOT_LAST);
    assign o_valid       = r_out_valid;
    assign o_state_value = r_state;
    assign o_visit_count = r_visits;
    assign o_cycle_total = r_total;
    assign o_applicable  = r_appl;
    assign o_last_result = r_last;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

// Testbench for the random excursions variant counter.
module testbench;

    localparam int MAX_LEN = 16777216;
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // The walk sum is one bit wider than the counters and signed, so that it can hold
    // both -MAX_LEN and +MAX_LEN.
    localparam logic signed [CNT_W:0] SUM_LIMIT = (CNT_W + 1)'(MAX_LEN);
    localparam logic signed [CNT_W:0] SUM_STEP  = (CNT_W + 1)'(1);

    // One result word as the block presents it on its output ports.
    typedef struct packed {
        logic [revc_pkg::STATE_W-1:0] state_value;
        logic [CNT_W-1:0]             visit_count;
        logic [CNT_W-1:0]             cycle_total;
        logic                         applicable;
        logic                         last_result;
    } t_excursion_result;

    // Every input of the block has a known value from time zero onward.
    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]                    i_cfg_wdata = '0;
    logic                                i_valid     = 1'b0;
    logic                                o_stall;
    logic                                i_bit_req   = 1'b0;
    logic                                i_last_bit  = 1'b0;
    logic                                o_valid;
    logic                                i_stall     = 1'b0;
    logic signed [revc_pkg::STATE_W-1:0] o_state_value;
    logic [CNT_W-1:0]                    o_visit_count;
    logic [CNT_W-1:0]                    o_cycle_total;
    logic                                o_applicable;
    logic                                o_last_result;

    // Our own copy of the walk: running sum, cycle count, one visit counter per
    // reported state (slots 0..8 hold states -9..-1, slots 9..17 hold 1..9), and the
    // current threshold for the applicable flag.
    logic signed [CNT_W:0]     walk_pos;
    logic [CNT_W-1:0]          cycle_cnt;
    logic [CNT_W-1:0]          visit_cnt [revc_pkg::NUM_STATES];
    logic [CNT_W-1:0]          min_cycles_cfg;

    // Result words still owed by the block, oldest first.
    t_excursion_result         pending_results [$];

    int                        err_count  = 0;
    // Idle intensity of the sender and of the receiver: 0 never idles, 1 idles now
    // and then, 2 idles most of the time.
    int                        src_mode   = 0;
    int                        sink_mode  = 0;
    int                        stall_left = 0;

    random_excursion_variant_counter #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_bit_req    (i_bit_req),
        .i_last_bit   (i_last_bit),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_state_value(o_state_value),
        .o_visit_count(o_visit_count),
        .o_cycle_total(o_cycle_total),
        .o_applicable (o_applicable),
        .o_last_result(o_last_result)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop in case the block hangs or never delivers an owed result word. The
    // limit is meant to exceed the slowest legal run, with every word closing a
    // sequence and every stall at its longest.
    initial begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Saturating increment shared by the cycle count and the visit counters.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v < CNT_W'(MAX_LEN)) ? v + CNT_W'(1) : CNT_W'(MAX_LEN);
    endfunction

    // Length of the next idle stretch. Most stretches are zero or short; a few are
    // long enough to let the other side fill up or run dry.
    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 70 - 25 * mode) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic clear_walk();
        walk_pos  = '0;
        cycle_cnt = '0;
        foreach (visit_cnt[k]) begin
            visit_cnt[k] = '0;
        end
    endtask

    // Advances our walk by one accepted word. A word that closes a sequence queues
    // the 18 result words the block owes for it and starts a fresh walk.
    task automatic predict_word(input logic up, input logic closes);
        int                slot;
        int                k;
        t_excursion_result r;
        walk_pos = up ? walk_pos + SUM_STEP : walk_pos - SUM_STEP;
        if (walk_pos > SUM_LIMIT) begin
            walk_pos = SUM_LIMIT;
        end
        if (walk_pos < -SUM_LIMIT) begin
            walk_pos = -SUM_LIMIT;
        end
        if (walk_pos == 0) begin
            cycle_cnt = bump(cycle_cnt);
        end else if (walk_pos >= -revc_pkg::STATE_SPAN && walk_pos <= revc_pkg::STATE_SPAN) begin
            slot = (walk_pos < 0) ? int'(walk_pos) + revc_pkg::STATE_SPAN
                                  : int'(walk_pos) + revc_pkg::STATE_SPAN - 1;
            visit_cnt[slot] = bump(visit_cnt[slot]);
        end
        if (closes) begin
            // A walk that ends away from zero closes its open excursion as one more
            // cycle.
            if (walk_pos != 0) begin
                cycle_cnt = bump(cycle_cnt);
            end
            for (k = 0; k < revc_pkg::NUM_STATES; k++) begin
                r.state_value = revc_pkg::STATE_W'((k < revc_pkg::STATE_SPAN)
                                                   ? k - revc_pkg::STATE_SPAN
                                                   : k - revc_pkg::STATE_SPAN + 1);
                r.visit_count = visit_cnt[k];
                r.cycle_total = cycle_cnt;
                r.applicable  = (cycle_cnt >= min_cycles_cfg);
                r.last_result = (k == revc_pkg::NUM_STATES - 1);
                pending_results.push_back(r);
            end
            clear_walk();
        end
    endtask

    // Presents one word and returns at the edge that accepts it. Valid stays high
    // afterwards, so a following call with no gap keeps the input side busy; a gap
    // or a pause lowers it first.
    task automatic send_word(input logic up, input logic closes);
        int gap;
        gap = pick_gap(src_mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_bit_req  <= up;
        i_last_bit <= closes;
        do @(posedge i_clk); while (o_stall);
        predict_word(up, closes);
    endtask

    // Stops sending, waits until every owed result word has arrived, then lets the
    // block finish any trailing write back before anything else happens.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (25) @(posedge i_clk);
    endtask

    // The register is only written while the block has nothing in flight.
    task automatic write_min_cycles(input logic [CNT_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        min_cycles_cfg = value;
    endtask

    // One phase of random walks under a fixed threshold. Sequences are mostly short
    // so that many readouts happen; a few are long. Each sequence leans up, leans
    // down or is fair, so that the outer states and the states beyond nine are
    // reached as well as frequent returns to zero. The phase always ends on a closing
    // word so that the following register write finds an empty walk.
    task automatic run_walk_phase(input int n_words, input logic [CNT_W-1:0] min_value,
                                  input int src_idle, input int sink_idle);
        int sent;
        int run_len;
        int bias;
        write_min_cycles(min_value);
        src_mode  = src_idle;
        sink_mode = sink_idle;
        sent      = 0;
        while (sent < n_words) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 24);
            if (run_len > n_words - sent) begin
                run_len = n_words - sent;
            end
            case ($urandom_range(0, 3))
                0: bias = 80;
                1: bias = 20;
                default: bias = 50;
            endcase
            for (int i = 1; i <= run_len; i++) begin
                send_word($urandom_range(0, 99) < bias, i == run_len);
            end
            sent += run_len;
        end
    endtask

    // Under the reset threshold of 500 nothing is applicable. The walk goes up, back
    // to zero, down and back to zero again, so the closing word finds a zero sum and
    // adds no extra cycle.
    task automatic test_zero_returns();
        src_mode  = 0;
        sink_mode = 0;
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b1);
        drain();
    endtask

    // Walks straight up to +10 and then straight down to -10, closing on a nonzero
    // sum each time. The states beyond nine are not counted, and the open excursion
    // becomes the single cycle. A threshold of zero makes every readout applicable.
    task automatic test_outer_states();
        write_min_cycles('0);
        src_mode  = 1;
        sink_mode = 1;
        for (int i = 1; i <= 10; i++) begin
            send_word(1'b1, i == 10);
        end
        for (int i = 1; i <= 10; i++) begin
            send_word(1'b0, i == 10);
        end
    endtask

    // The largest threshold and the one with all lower bits set are never met; zero
    // and one always are. Between them every bit of the register takes both values.
    task automatic test_min_cycles_extremes();
        run_walk_phase(28, CNT_W'(MAX_LEN), 1, 1);
        run_walk_phase(28, CNT_W'(MAX_LEN - 1), 0, 0);
        run_walk_phase(28, '0, 2, 1);
        run_walk_phase(28, CNT_W'(1), 1, 2);
    endtask

    // Small thresholds sit right among the cycle counts of short walks, so the
    // applicable flag flips back and forth around its boundary. Idle intensities
    // are drawn anew for each phase and can include phases with no idling at all.
    task automatic test_random_walks();
        for (int p = 0; p < 7; p++) begin
            run_walk_phase(28, CNT_W'($urandom_range(0, 10)),
                           $urandom_range(0, 2), $urandom_range(0, 2));
        end
    endtask

    // Receiver backpressure: stall stretches of random length, chosen anew whenever
    // the previous one has run out.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = pick_gap(sink_mode);
        end
        i_stall <= (stall_left > 0);
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end
    end

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Every accepted result word is checked against the oldest owed word.
    always @(posedge i_clk) begin
        t_excursion_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: result word with nothing owed: state %0d, visits %0d",
                         $time, o_state_value, o_visit_count);
            end else begin
                want = pending_results.pop_front();
                compare_field("state_value", 32'($signed(want.state_value)),
                              32'(o_state_value));
                compare_field("visit_count", 32'(want.visit_count), 32'(o_visit_count));
                compare_field("cycle_total", 32'(want.cycle_total), 32'(o_cycle_total));
                compare_field("applicable", 32'(want.applicable), 32'(o_applicable));
                compare_field("last_result", 32'(want.last_result), 32'(o_last_result));
            end
        end
    end

    initial begin
        clear_walk();
        min_cycles_cfg = CNT_W'(revc_pkg::MIN_CYCLES_RESET);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_returns();
        test_outer_states();
        test_min_cycles_extremes();
        test_random_walks();
        drain();
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
